FILE: rtl/core/annexb_nal_unit_splitter_core_defines.svh
// assertion macros for the annex b nal unit splitter core
`ifndef ANNEXB_NAL_UNIT_SPLITTER_CORE_DEFINES_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication
`define ANNEXB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ANNEXB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/annexb_pkg.sv
// shared types, constants and result packing for the annex b nal unit splitter
package annexb_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [5:0] TYPE_LIMIT_RST = 6'd24;
	localparam logic [7:0] HDR_FORBIDDEN = 8'h80;
	localparam logic [7:0] HDR_REF_IDC = 8'h60;
	localparam logic [7:0] HDR_TYPE = 8'h1F;

	typedef logic [OFFSET_BITS-1:0] offset_t;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_HEAD,
		PH_BODY,
		PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_FORBIDDEN,
		ST_RESERVED,
		ST_ZERO_HDR,
		ST_NO_LEAD,
		ST_EARLY_END
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] unit_start;
		logic [2:0]  code_length;
		logic [7:0]  header_value;
		logic [4:0]  unit_type;
		logic        is_reference;
		logic [2:0]  status;
		logic [31:0] unit_end;
		logic        run_last;
	} out_item_t;

	typedef struct packed {
		out_item_t first;
		out_item_t second;
		logic      two;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic pending;
	} back_stat_t;

	function automatic out_item_t make_result(offset_t start, logic [2:0] len,
			logic [7:0] hdr, status_t st, offset_t end_off);
		out_item_t r;
		r.unit_start = 32'(start);
		r.code_length = len;
		r.header_value = hdr;
		r.unit_type = (st == ST_OK) ? hdr[4:0] : 5'd0;
		r.is_reference = ((st == ST_OK) || (st == ST_RESERVED)) &&
			((hdr & HDR_REF_IDC) != 8'd0);
		r.status = st;
		r.unit_end = 32'(end_off);
		r.run_last = 1'b0;
		return r;
	endfunction

endpackage

FILE: rtl/core/annexb_front.sv
// front end: start code scan, header classification and result generation
module annexb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  annexb_pkg::in_item_t in_data,
	input  logic [5:0]           type_limit,
	input  annexb_pkg::fifo_stat_t q_stat,
	output logic                 q_push,
	output annexb_pkg::q_entry_t q_wdata
);

	annexb_pkg::phase_t    phase_q, phase_d;
	annexb_pkg::offset_t   pos_q, scan_q, cur_start_q;
	logic [23:0]           recent_q;
	logic [2:0]            cur_len_q;
	logic [7:0]            cur_hdr_q;
	annexb_pkg::status_t   cur_st_q;

	logic                  accept;
	logic [7:0]            b;
	logic                  last;
	annexb_pkg::offset_t   p, nxt, span, ns;
	logic                  lead_fail, lead_go, found, four;
	logic [2:0]            lead_len, nl;
	annexb_pkg::status_t   hdr_st;

	annexb_pkg::out_item_t r0, r1;
	logic [1:0]            cnt;

	assign in_ready = !q_stat.full;
	assign accept = in_valid && in_ready;
	assign b = in_data.data_byte;
	assign last = in_data.last_byte;
	assign p = pos_q;
	assign nxt = pos_q + annexb_pkg::offset_t'(1);
	assign span = pos_q - scan_q;

	// leading start code
	always_comb begin
		lead_fail = 1'b0;
		lead_go = 1'b0;
		lead_len = 3'd3;
		if (p == annexb_pkg::offset_t'(0) || p == annexb_pkg::offset_t'(1)) begin
			lead_fail = (b != 8'd0);
		end else if (p == annexb_pkg::offset_t'(2)) begin
			if (b == 8'd1) begin
				lead_go = 1'b1;
			end else if (b != 8'd0) begin
				lead_fail = 1'b1;
			end
		end else if (p == annexb_pkg::offset_t'(3) && b == 8'd1) begin
			lead_go = 1'b1;
			lead_len = 3'd4;
		end else begin
			lead_fail = 1'b1;
		end
	end

	// header classification
	always_comb begin
		if ((b & annexb_pkg::HDR_FORBIDDEN) != 8'd0) begin
			hdr_st = annexb_pkg::ST_FORBIDDEN;
		end else if ({1'b0, b[4:0]} >= type_limit) begin
			hdr_st = annexb_pkg::ST_RESERVED;
		end else begin
			hdr_st = annexb_pkg::ST_OK;
		end
	end

	// start code in the body
	assign found = (b == 8'd1) && (recent_q[15:0] == 16'd0) &&
		(span >= annexb_pkg::offset_t'(2));
	assign four = (span >= annexb_pkg::offset_t'(3)) && (recent_q[23:16] == 8'd0);
	assign ns = four ? (pos_q - annexb_pkg::offset_t'(3)) : (pos_q - annexb_pkg::offset_t'(2));
	assign nl = four ? 3'd4 : 3'd3;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			annexb_pkg::PH_LEAD: begin
				if (lead_fail) begin
					phase_d = annexb_pkg::PH_HALT;
				end else if (lead_go) begin
					phase_d = annexb_pkg::PH_HEAD;
				end
			end
			annexb_pkg::PH_HEAD: begin
				phase_d = (b == 8'd0) ? annexb_pkg::PH_HALT : annexb_pkg::PH_BODY;
			end
			annexb_pkg::PH_BODY: begin
				if (found) begin
					phase_d = annexb_pkg::PH_HEAD;
				end
			end
			annexb_pkg::PH_HALT: begin
				phase_d = annexb_pkg::PH_HALT;
			end
			default: begin
				phase_d = annexb_pkg::PH_LEAD;
			end
		endcase
		if (last) begin
			phase_d = annexb_pkg::PH_LEAD;
		end
	end

	// results
	always_comb begin
		r0 = '0;
		r1 = '0;
		cnt = 2'd0;
		unique case (phase_q)
			annexb_pkg::PH_LEAD: begin
				if (lead_fail || (last && !lead_go)) begin
					r0 = annexb_pkg::make_result('0, 3'd0, 8'd0, annexb_pkg::ST_NO_LEAD, nxt);
					cnt = 2'd1;
				end else if (last) begin
					r0 = annexb_pkg::make_result('0, lead_len, 8'd0,
						annexb_pkg::ST_EARLY_END, nxt);
					cnt = 2'd1;
				end
			end
			annexb_pkg::PH_HEAD: begin
				if (b == 8'd0) begin
					r0 = annexb_pkg::make_result(cur_start_q, cur_len_q, 8'd0,
						annexb_pkg::ST_ZERO_HDR, nxt);
					cnt = 2'd1;
				end else if (last) begin
					r0 = annexb_pkg::make_result(cur_start_q, cur_len_q, b, hdr_st, nxt);
					cnt = 2'd1;
				end
			end
			annexb_pkg::PH_BODY: begin
				if (found) begin
					r0 = annexb_pkg::make_result(cur_start_q, cur_len_q, cur_hdr_q,
						cur_st_q, ns);
					cnt = 2'd1;
					if (last) begin
						r1 = annexb_pkg::make_result(ns, nl, 8'd0,
							annexb_pkg::ST_EARLY_END, nxt);
						cnt = 2'd2;
					end
				end else if (last) begin
					r0 = annexb_pkg::make_result(cur_start_q, cur_len_q, cur_hdr_q,
						cur_st_q, nxt);
					cnt = 2'd1;
				end
			end
			annexb_pkg::PH_HALT: begin
				cnt = 2'd0;
			end
			default: begin
				cnt = 2'd0;
			end
		endcase
		r0.run_last = (cnt == 2'd1);
		r1.run_last = 1'b1;
	end

	assign q_push = accept && (cnt != 2'd0);
	assign q_wdata = '{first: r0, second: r1, two: (cnt == 2'd2)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= annexb_pkg::PH_LEAD;
			pos_q <= '0;
			scan_q <= '0;
			recent_q <= '0;
			cur_start_q <= '0;
			cur_len_q <= '0;
			cur_hdr_q <= '0;
			cur_st_q <= annexb_pkg::ST_OK;
		end else if (accept) begin
			phase_q <= phase_d;
			if (last) begin
				pos_q <= '0;
				scan_q <= '0;
				recent_q <= '0;
				cur_start_q <= '0;
				cur_len_q <= '0;
				cur_hdr_q <= '0;
				cur_st_q <= annexb_pkg::ST_OK;
			end else begin
				pos_q <= nxt;
				recent_q <= {recent_q[15:0], b};
				if (phase_q == annexb_pkg::PH_LEAD && lead_go) begin
					cur_start_q <= '0;
					cur_len_q <= lead_len;
					scan_q <= pos_q + annexb_pkg::offset_t'(2);
				end
				if (phase_q == annexb_pkg::PH_HEAD && b != 8'd0) begin
					cur_hdr_q <= b;
					cur_st_q <= hdr_st;
				end
				if (phase_q == annexb_pkg::PH_BODY && found) begin
					cur_start_q <= ns;
					cur_len_q <= nl;
					cur_hdr_q <= '0;
					cur_st_q <= annexb_pkg::ST_OK;
					scan_q <= pos_q + annexb_pkg::offset_t'(2);
				end
			end
		end
	end

endmodule

FILE: rtl/core/annexb_fifo.sv
// result queue between the front end and the output stage
module annexb_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  annexb_pkg::q_entry_t   wdata,
	input  logic                   pop,
	output annexb_pkg::q_entry_t   rdata,
	output annexb_pkg::fifo_stat_t stat
);

	annexb_pkg::q_entry_t            mem_q [annexb_pkg::QUEUE_DEPTH];
	logic [annexb_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [annexb_pkg::QCNT_W-1:0]   count_q;

	assign stat.full = (count_q == annexb_pkg::QCNT_W'(annexb_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + annexb_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + annexb_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + annexb_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - annexb_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/annexb_back.sv
// output stage: unpacks queued result pairs onto the output channel
module annexb_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  annexb_pkg::q_entry_t    q_rdata,
	input  annexb_pkg::fifo_stat_t  q_stat,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output annexb_pkg::out_item_t   out_data,
	output annexb_pkg::back_stat_t  stat
);

	logic                  out_valid_q;
	annexb_pkg::out_item_t out_q, second_q;
	logic                  pending_q;
	logic                  adv;

	assign adv = !out_valid_q || out_ready;
	assign q_pop = adv && !pending_q && !q_stat.empty;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign stat.pending = pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pending_q <= 1'b0;
		end else if (adv) begin
			if (pending_q) begin
				out_valid_q <= 1'b1;
				pending_q <= 1'b0;
			end else if (!q_stat.empty) begin
				out_valid_q <= 1'b1;
				pending_q <= q_rdata.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pending_q) begin
				out_q <= second_q;
			end else if (!q_stat.empty) begin
				out_q <= q_rdata.first;
				second_q <= q_rdata.second;
			end
		end
	end

endmodule

FILE: rtl/core/annexb_nal_unit_splitter_core.sv
// top level of the annex b nal unit splitter
//
// channel   dir  handshake                payload
// in        in   in_valid / in_ready      annexb_pkg::in_item_t
// out       out  out_valid / out_ready    annexb_pkg::out_item_t
// cfg       in   cfg_we                   cfg_wdata (reserved type limit)
//
// one byte per cycle is accepted while the result queue has room
// a byte that ends a unit and completes a start code at stream end gives two
// results, which the output stage sends in turn, holding the second in a register
// each result is registered in the queue and then in the output register
// reset returns the parser to the leading start code at offset 0, limit 24
// a stalled output fills the four-entry queue, then in_ready drops
`include "annexb_nal_unit_splitter_core_defines.svh"

module annexb_nal_unit_splitter_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  annexb_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output annexb_pkg::out_item_t out_data,
	input  logic                  cfg_we,
	input  logic [5:0]            cfg_wdata
);

	logic [5:0]             type_limit_q;
	logic                   q_push, q_pop;
	annexb_pkg::q_entry_t   q_wdata, q_rdata;
	annexb_pkg::fifo_stat_t q_stat;
	annexb_pkg::back_stat_t b_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_limit_q <= annexb_pkg::TYPE_LIMIT_RST;
		end else if (cfg_we) begin
			type_limit_q <= cfg_wdata;
		end
	end

	annexb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.type_limit (type_limit_q),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	annexb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	annexb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rdata   (q_rdata),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.stat      (b_stat)
	);

	`ANNEXB_ASSERT_IMPL(a_no_overflow, q_push, !q_stat.full, "push into full queue")
	`ANNEXB_ASSERT_IMPL(a_pair_pending, out_valid && !out_data.run_last, b_stat.pending,
		"non-final result without queued partner")
	`ANNEXB_ASSERT_IMPL(a_early_end_last,
		out_valid && (out_data.status == annexb_pkg::ST_EARLY_END), out_data.run_last,
		"early end result not final")
	`ANNEXB_ASSERT_NEXT(a_pending_sent, b_stat.pending && out_ready,
		!b_stat.pending && out_valid && out_data.run_last, "second result not sent")

endmodule
